// ===== sv/vt52_pkg.sv =====
`default_nettype none
package vt52_pkg;

    localparam int TAB_STOP   = 8;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [1:0] OP_CHAR   = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] CFG_COLOUR   = 2'd0;
    localparam logic [1:0] CFG_LAST_ROW = 2'd1;
    localparam logic [1:0] CFG_LAST_COL = 2'd2;

    localparam logic [7:0] RST_ATTR     = 8'h07;
    localparam logic [7:0] RST_LAST_ROW = 8'd24;
    localparam logic [7:0] RST_LAST_COL = 8'd79;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] out_char;
        logic [7:0] out_attr;
        logic [7:0] out_row;
        logic [7:0] out_col;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    function automatic t_result make_result(input logic [1:0] op, input logic [7:0] chr,
                                            input logic [7:0] attr, input logic [7:0] row,
                                            input logic [7:0] col);
        t_result r;
        r.op       = op;
        r.out_char = chr;
        r.out_attr = attr;
        r.out_row  = row;
        r.out_col  = col;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vt52_decode.sv =====
`default_nettype none
module vt52_decode #(
    parameter int TAB_STOP = vt52_pkg::TAB_STOP
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_upd,
    input  wire logic [7:0]         i_ch,
    input  wire logic [7:0]         i_row,
    input  wire logic [7:0]         i_col,
    input  wire logic               i_colour,
    input  wire logic [7:0]         i_last_row,
    input  wire logic [7:0]         i_last_col,
    output vt52_pkg::t_dec_out      o_dec
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ESC  = 3'd1,
        ST_FG   = 3'd2,
        ST_BG   = 3'd3,
        ST_YROW = 3'd4,
        ST_YCOL = 3'd5
    } t_esc_state;

    localparam int NSTOP    = 255 / TAB_STOP;
    localparam int TAB_LAST = NSTOP * TAB_STOP;

    t_esc_state r_state, n_state;
    logic [7:0] r_attr, n_attr;
    logic [7:0] r_crow, n_crow;
    logic [7:0] r_ccol, n_ccol;

    logic [7:0] w_tab_col;
    logic [7:0] w_row_dn, w_row_up, w_col_dn, w_col_up, w_yval;
    vt52_pkg::t_dec_out w_dec;

    function automatic logic [7:0] apply_attr(input logic [7:0] c, input logic [7:0] cand,
                                              input logic [7:0] attr, input logic colour);
        logic [7:0] a;
        a = attr;
        unique case (c)
            vt52_pkg::CH_UNDER: begin
                if (!colour) a = {attr[7], 3'b000, attr[3], 3'b001};
            end
            vt52_pkg::CH_BANG:  a = {attr[7], 3'b111, attr[3], 3'b000};
            vt52_pkg::CH_SPACE: a = vt52_pkg::RST_ATTR;
            vt52_pkg::CH_PLUS:  a = attr | 8'h08;
            vt52_pkg::CH_STAR:  a = attr | 8'h80;
            default: begin
                if (colour) a = cand;
            end
        endcase
        return a;
    endfunction

    // next tab stop above the sampled column, saturating at the last one
    always_comb begin
        w_tab_col = 8'(TAB_LAST);
        for (int k = NSTOP; k >= 1; k--) begin
            if ({1'b0, i_col} < 9'(k * TAB_STOP)) w_tab_col = 8'(k * TAB_STOP);
        end
    end

    assign w_row_dn = (r_crow != 8'd0) ? r_crow - 8'd1 : r_crow;
    assign w_row_up = (r_crow < i_last_row) ? r_crow + 8'd1 : r_crow;
    assign w_col_dn = (r_ccol != 8'd0) ? r_ccol - 8'd1 : r_ccol;
    assign w_col_up = (r_ccol < i_last_col) ? r_ccol + 8'd1 : r_ccol;
    assign w_yval   = i_ch - vt52_pkg::CH_SPACE;

    always_comb begin
        n_state = r_state;
        n_attr  = r_attr;
        n_crow  = r_crow;
        n_ccol  = r_ccol;
        w_dec.num  = 2'd0;
        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0);
        w_dec.res1 = w_dec.res0;
        unique case (r_state)
            ST_ESC: begin
                n_state = ST_IDLE;
                unique case (i_ch)
                    vt52_pkg::CH_A: begin
                        n_crow = w_row_dn;
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           w_row_dn, r_ccol);
                    end
                    vt52_pkg::CH_B: begin
                        n_crow = w_row_up;
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           w_row_up, r_ccol);
                    end
                    vt52_pkg::CH_C: begin
                        n_ccol = w_col_up;
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           r_crow, w_col_up);
                    end
                    vt52_pkg::CH_D: begin
                        n_ccol = w_col_dn;
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           r_crow, w_col_dn);
                    end
                    vt52_pkg::CH_E: begin
                        n_attr = vt52_pkg::RST_ATTR;
                        n_crow = 8'd0;
                        n_ccol = 8'd0;
                        w_dec.num  = 2'd2;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CLEAR, 8'd0,
                                                           vt52_pkg::RST_ATTR, 8'd0, 8'd0);
                        w_dec.res1 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           8'd0, 8'd0);
                    end
                    vt52_pkg::CH_H: begin
                        n_crow = 8'd0;
                        n_ccol = 8'd0;
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                           8'd0, 8'd0);
                    end
                    vt52_pkg::CH_J: begin
                        w_dec.num  = 2'd1;
                        w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CLEAR, 8'd0, r_attr,
                                                           8'd0, 8'd0);
                    end
                    vt52_pkg::CH_R: n_state = ST_FG;
                    vt52_pkg::CH_S: n_state = ST_BG;
                    vt52_pkg::CH_Y: n_state = ST_YROW;
                    default: ;
                endcase
            end
            ST_FG: begin
                n_state = ST_IDLE;
                n_attr  = apply_attr(i_ch, {r_attr[7:4], i_ch[3:0]}, r_attr, i_colour);
            end
            ST_BG: begin
                n_state = ST_IDLE;
                n_attr  = apply_attr(i_ch, {i_ch[3:0], r_attr[3:0]}, r_attr, i_colour);
            end
            ST_YROW: begin
                n_state = ST_YCOL;
                n_crow  = w_yval;
            end
            ST_YCOL: begin
                n_state = ST_IDLE;
                n_ccol  = w_yval;
                w_dec.num  = 2'd1;
                w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                   r_crow, w_yval);
            end
            default: begin
                n_state = ST_IDLE;
                priority if (i_ch[7:5] != 3'b000) begin
                    w_dec.num  = 2'd1;
                    w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CHAR, i_ch, r_attr,
                                                       8'd0, 8'd0);
                end else if (i_ch == vt52_pkg::CH_TAB) begin
                    n_crow = i_row;
                    n_ccol = w_tab_col;
                    w_dec.num  = 2'd1;
                    w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                       i_row, w_tab_col);
                end else if (i_ch == vt52_pkg::CH_FF) begin
                    n_crow = 8'd0;
                    n_ccol = 8'd0;
                    w_dec.num  = 2'd2;
                    w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_CURSOR, 8'd0, 8'd0,
                                                       8'd0, 8'd0);
                    w_dec.res1 = vt52_pkg::make_result(vt52_pkg::OP_CLEAR, 8'd0, r_attr,
                                                       8'd0, 8'd0);
                end else if (i_ch == vt52_pkg::CH_ESC) begin
                    n_state = ST_ESC;
                    n_crow  = i_row;
                    n_ccol  = i_col;
                end else begin
                    w_dec.num  = 2'd1;
                    w_dec.res0 = vt52_pkg::make_result(vt52_pkg::OP_RAW, i_ch, 8'd0,
                                                       8'd0, 8'd0);
                end
            end
        endcase
        w_dec.res0.last = (w_dec.num == 2'd1);
        w_dec.res1.last = 1'b1;
    end

    assign o_dec = w_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_attr  <= vt52_pkg::RST_ATTR;
            r_crow  <= 8'd0;
            r_ccol  <= 8'd0;
        end else if (i_upd) begin
            r_state <= n_state;
            r_attr  <= n_attr;
            r_crow  <= n_crow;
            r_ccol  <= n_ccol;
        end
    end

    a_y_row_then_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && r_state == ST_YROW) |=> (r_state == ST_YCOL))
        else $error("Y row byte not followed by column state");
    a_two_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dec.num == 2'd2) |-> (!w_dec.res0.last && w_dec.res1.last))
        else $error("last flag misplaced on two-result byte");
    a_esc_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd && n_state != ST_IDLE) |-> (w_dec.num == 2'd0))
        else $error("result emitted inside an escape sequence");

endmodule
`default_nettype wire

// ===== sv/vt52_outq.sv =====
`default_nettype none
module vt52_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_push_n,
    input  wire vt52_pkg::t_result  i_res0,
    input  wire vt52_pkg::t_result  i_res1,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output vt52_pkg::t_result       o_head,
    output logic                    o_room
);

    localparam int DEPTH = vt52_pkg::OUTQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    vt52_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  w_wr1;

    assign w_wr1   = r_wr + PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // room for a two-beat byte once this cycle's pop is counted
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2)) ||
                     ((r_count == CNT_W'(DEPTH - 1)) && i_pop);

    always_comb begin
        n_rd    = i_pop ? r_rd + PTR_W'(1) : r_rd;
        n_wr    = r_wr + PTR_W'(i_push_n);
        n_count = r_count + CNT_W'(i_push_n) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_room)
        else $error("push into output queue without room");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("output queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty output queue");

endmodule
`default_nettype wire

// ===== sv/vt52_escape_decoder.sv =====
// VT52 escape decoder: terminal bytes in, display commands out.
// Input channel: i_in_valid / o_in_stall with i_ch, i_cur_row, i_cur_col.
// The cursor fields are only looked at for ESC and TAB bytes.
// Output channel: o_out_valid / i_out_stall with o_op, o_out_char,
// o_out_attr, o_out_row, o_out_col and o_last; o_last marks the final
// beat caused by one byte. A byte gives zero, one or two beats.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 colour display, 1 last row, 2 last column); write only when idle.
// A byte passes through the input register, then the output queue.
// Throughput: one byte per cycle while the receiver does not stall and each
// byte gives at most one beat; a two-beat byte (ESC E, form feed) needs two output beats.
// The input register feeds decode logic that writes a four-entry output
// queue; a byte leaves the input register only when two entries are free,
// counting an entry popped in the same cycle.
// When the receiver stalls, the queue fills and o_in_stall rises after the
// input register holds a byte; nothing is dropped.
// Reset (synchronous, active low) empties the queue, returns to the idle
// escape state, attribute 0x07, cursor 0,0 and the default registers.
`default_nettype none
module vt52_escape_decoder #(
    parameter int TAB_STOP = vt52_pkg::TAB_STOP
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic [7:0] i_cur_row,
    input  wire logic [7:0] i_cur_col,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_op,
    output logic [7:0]      o_out_char,
    output logic [7:0]      o_out_attr,
    output logic [7:0]      o_out_row,
    output logic [7:0]      o_out_col,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_colour;
    logic [7:0] r_last_row;
    logic [7:0] r_last_col;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic [7:0] r_in_row;
    logic [7:0] r_in_col;

    logic               w_room;
    logic               w_adv;
    logic               w_pop;
    logic               w_load;
    logic [1:0]         w_push_n;
    vt52_pkg::t_dec_out w_dec;
    vt52_pkg::t_result  w_head;

    assign w_adv      = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;
    assign w_load     = !o_in_stall;
    assign w_pop      = o_out_valid && !i_out_stall;
    assign w_push_n   = w_adv ? w_dec.num : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour   <= 1'b1;
            r_last_row <= vt52_pkg::RST_LAST_ROW;
            r_last_col <= vt52_pkg::RST_LAST_COL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vt52_pkg::CFG_COLOUR:   r_colour   <= i_cfg_data[0];
                vt52_pkg::CFG_LAST_ROW: r_last_row <= i_cfg_data;
                vt52_pkg::CFG_LAST_COL: r_last_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_ch  <= i_ch;
            r_in_row <= i_cur_row;
            r_in_col <= i_cur_col;
        end
    end

    vt52_decode #(
        .TAB_STOP (TAB_STOP)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (w_adv),
        .i_ch       (r_in_ch),
        .i_row      (r_in_row),
        .i_col      (r_in_col),
        .i_colour   (r_colour),
        .i_last_row (r_last_row),
        .i_last_col (r_last_col),
        .o_dec      (w_dec)
    );

    vt52_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_dec.res0),
        .i_res1   (w_dec.res1),
        .i_pop    (w_pop),
        .o_valid  (o_out_valid),
        .o_head   (w_head),
        .o_room   (w_room)
    );

    assign o_op       = w_head.op;
    assign o_out_char = w_head.out_char;
    assign o_out_attr = w_head.out_attr;
    assign o_out_row  = w_head.out_row;
    assign o_out_col  = w_head.out_col;
    assign o_last     = w_head.last;

endmodule
`default_nettype wire
